[hdl/hbl_pkg.sv]
// hbl_pkg: widths, types and helpers shared by the hsv bilinear table lookup
// depends on nothing; every other file of the block uses it
package hbl_pkg;

  localparam int GRID_SIDE   = 17;
  localparam int ENTRY_BITS  = 13;
  localparam int IN_ENTRY_W  = 13;
  localparam int IDX_W       = 5;
  localparam int PIX_W       = 8;
  localparam int NIB_W       = 4;
  localparam int NUM_CH      = 3;
  localparam int NUM_CORNER  = 4;
  localparam int CORNER_W    = 2;
  localparam int ENTRY_FRAC  = 12;

  localparam int WGT_ONE     = 2 ** NIB_W;
  localparam int WGT_W       = 2 * NIB_W + 1;
  localparam int ACC_W       = ENTRY_BITS + 2 * NIB_W;
  localparam int SCL_W       = ACC_W + PIX_W;
  localparam int FRAC_SHIFT  = ENTRY_FRAC + 2 * NIB_W;
  localparam int PIX_MAX     = 2 ** PIX_W - 1;

  localparam int HALF_W      = IDX_W - 1;
  localparam int BANK_SIDE   = (GRID_SIDE + 1) / 2;
  localparam int BANK_DEPTH  = BANK_SIDE * BANK_SIDE;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef logic [ENTRY_BITS-1:0] entry_t;
  typedef entry_t [NUM_CH-1:0] rgb_t;
  typedef rgb_t [NUM_CORNER-1:0] corner_t;
  typedef logic [WGT_W-1:0] wgt_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    rgb_t             data;
  } grid_wr_t;

  typedef struct packed {
    logic             en;
    logic [NIB_W-1:0] hrow;
    logic [NIB_W-1:0] scol;
  } grid_rd_t;

  typedef struct packed {
    wgt_t [NUM_CORNER-1:0] w;
    logic [PIX_W-1:0]      bright;
  } stage_t;

  // entry (row, col) lives in bank {row[0], col[0]} at (row/2, col/2)
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [HALF_W-1:0] hr,
                                                   input logic [HALF_W-1:0] hc);
    return BANK_AW'(int'(hr) * BANK_SIDE + int'(hc));
  endfunction

endpackage

[hdl/hbl_if.sv]
// hbl_in_if and hbl_out_if: valid/ready channels for the table lookup
// depends on hbl_pkg for field widths
interface hbl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [hbl_pkg::PIX_W-1:0]      hue;
  logic [hbl_pkg::PIX_W-1:0]      saturation;
  logic [hbl_pkg::PIX_W-1:0]      brightness;
  logic [hbl_pkg::IDX_W-1:0]      row_index;
  logic [hbl_pkg::IDX_W-1:0]      column_index;
  logic [hbl_pkg::IN_ENTRY_W-1:0] red_entry;
  logic [hbl_pkg::IN_ENTRY_W-1:0] green_entry;
  logic [hbl_pkg::IN_ENTRY_W-1:0] blue_entry;

  modport source (output valid, action, hue, saturation, brightness, row_index,
                  column_index, red_entry, green_entry, blue_entry, input ready);
  modport sink   (input valid, action, hue, saturation, brightness, row_index,
                  column_index, red_entry, green_entry, blue_entry, output ready);
endinterface

interface hbl_out_if;
  logic                     valid;
  logic                     ready;
  logic [hbl_pkg::PIX_W-1:0] red_out;
  logic [hbl_pkg::PIX_W-1:0] green_out;
  logic [hbl_pkg::PIX_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

[hdl/hbl_grid.sv]
// hbl_grid: color grid held in four parity banks, one write and four reads a cycle
// depends on hbl_pkg; read data is registered and returned in corner order
module hbl_grid (
  input  logic              clk,
  input  hbl_pkg::grid_wr_t wr,
  input  hbl_pkg::grid_rd_t rd,
  output hbl_pkg::corner_t  corner
);
  import hbl_pkg::*;

  logic [CORNER_W-1:0] par_r;
  rgb_t [NUM_CORNER-1:0] bank_q;
  logic [IDX_W-1:0] row_a, row_b, col_a, col_b;
  logic [CORNER_W-1:0] wr_bank;
  logic [BANK_AW-1:0] wr_addr;

  assign row_a   = IDX_W'(rd.hrow);
  assign row_b   = row_a + IDX_W'(1);
  assign col_a   = IDX_W'(rd.scol);
  assign col_b   = col_a + IDX_W'(1);
  assign wr_bank = {wr.row[0], wr.col[0]};
  assign wr_addr = bank_addr(wr.row[IDX_W-1:1], wr.col[IDX_W-1:1]);

  always_ff @(posedge clk) begin
    if (rd.en) begin
      par_r <= {rd.hrow[0], rd.scol[0]};
    end
  end

  for (genvar b = 0; b < NUM_CORNER; b++) begin : g_bank
    localparam logic [CORNER_W-1:0] BSEL = CORNER_W'(b);
    rgb_t bank_mem [BANK_DEPTH];
    rgb_t q_r;
    logic [IDX_W-1:0] rsel, csel;
    logic [BANK_AW-1:0] rd_addr;

    assign rsel    = (row_a[0] == BSEL[1]) ? row_a : row_b;
    assign csel    = (col_a[0] == BSEL[0]) ? col_a : col_b;
    assign rd_addr = bank_addr(rsel[IDX_W-1:1], csel[IDX_W-1:1]);

    always_ff @(posedge clk) begin
      if (wr.en && wr_bank == BSEL) begin
        bank_mem[wr_addr] <= wr.data;
      end
      if (rd.en) begin
        q_r <= bank_mem[rd_addr];
      end
    end

    assign bank_q[b] = q_r;
  end

  // corner {dr, dc} sits in bank {dr, dc} ^ {row parity, col parity}
  always_comb begin
    for (int k = 0; k < NUM_CORNER; k++) begin
      corner[k] = bank_q[CORNER_W'(k) ^ par_r];
    end
  end

endmodule

[hdl/hbl_interp.sv]
// hbl_interp: weight multiply, corner sum, brightness scale and saturating output
// depends on hbl_pkg and hbl_out_if; four register stages with valid bits
module hbl_interp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  hbl_pkg::stage_t  s_data,
  input  hbl_pkg::corner_t s_corner,
  hbl_out_if.source        out_chan
);
  import hbl_pkg::*;

  localparam int WHOLE_W = SCL_W - FRAC_SHIFT;

  logic en2, en3, en4, eno;
  logic v2_r, v3_r, v4_r, vo_r;
  logic [NUM_CH-1:0][NUM_CORNER-1:0][ACC_W-1:0] prod_nxt, prod_r;
  logic [PIX_W-1:0] bright2_r, bright3_r;
  logic [NUM_CH-1:0][ACC_W-1:0] acc_nxt, acc_r;
  logic [NUM_CH-1:0][SCL_W-1:0] scl_nxt, scl_r;
  logic [NUM_CH-1:0][PIX_W-1:0] pix_nxt, pix_r;
  logic [WHOLE_W-1:0] whole;

  assign eno     = !vo_r || out_chan.ready;
  assign en4     = !v4_r || eno;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign s_ready = en2;

  always_comb begin
    whole = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < NUM_CORNER; k++) begin
        prod_nxt[ch][k] = ACC_W'(s_data.w[k]) * ACC_W'(s_corner[k][ch]);
      end
      acc_nxt[ch] = prod_r[ch][0] + prod_r[ch][1] + prod_r[ch][2] + prod_r[ch][3];
      scl_nxt[ch] = SCL_W'(bright3_r) * SCL_W'(acc_r[ch]);
      whole = scl_r[ch][SCL_W-1:FRAC_SHIFT];
      if (SCL_W'(whole) > SCL_W'(PIX_MAX)) begin
        pix_nxt[ch] = PIX_W'(PIX_MAX);
      end else begin
        pix_nxt[ch] = PIX_W'(whole);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en2) v2_r <= s_valid;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (eno) vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s_valid) begin
      prod_r    <= prod_nxt;
      bright2_r <= s_data.bright;
    end
    if (en3 && v2_r) begin
      acc_r     <= acc_nxt;
      bright3_r <= bright2_r;
    end
    if (en4 && v3_r) begin
      scl_r <= scl_nxt;
    end
    if (eno && v4_r) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_chan.valid     = vo_r;
  assign out_chan.red_out   = pix_r[0];
  assign out_chan.green_out = pix_r[1];
  assign out_chan.blue_out  = pix_r[2];

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid && s_ready |=> v2_r)
    else $error("item taken from stage one did not reach the multiply stage");

  a_scale_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !eno |=> v4_r && $stable(scl_r))
    else $error("scaled item changed while the output stage was blocked");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && !out_chan.ready && v2_r && v3_r && v4_r |-> !s_ready)
    else $error("pipeline took an item with every stage full and output stalled");

endmodule

[hdl/hsv_bilinear_table_lookup.sv]
// hsv_bilinear_table_lookup: hsv to rgb through a bilinearly interpolated color grid
// depends on hbl_pkg, hbl_if, hbl_grid and hbl_interp
//
// in_chan carries two kinds of item. a load item (action 0) writes one grid
// entry at row_index/column_index; rows or columns above 16 are dropped. a
// lookup item (action 1) reads the four entries around hue/saturation and
// returns one rgb item on out_chan. loads give no result.
// an entry must be loaded before any lookup reads it; a lookup accepted on
// the cycle after a load already sees that load.
// path: an accepted lookup passes through the grid read, multiply, sum, scale
// and output registers in that order before it is presented on out_chan.
// throughput: one item per cycle unless out_chan stalls, loads and lookups mixed
// freely; the grid is split into four row/column parity banks so the four
// corner reads of a lookup and one load write fit in a single cycle.
// reset clears every valid bit; grid contents are undefined until loaded.
// when out_chan stalls, the stages close up their bubbles and in_chan.ready
// falls only once every stage holds an item; nothing is lost or repeated.
module hsv_bilinear_table_lookup (
  input  logic      clk,
  input  logic      rst_n,
  hbl_in_if.sink    in_chan,
  hbl_out_if.source out_chan
);
  import hbl_pkg::*;

  logic in_ready, s1_ready, lookup;
  logic s1_valid_r, s1_valid_nxt;
  stage_t s1_data_r, s1_data_nxt;
  grid_wr_t grid_wr;
  grid_rd_t grid_rd;
  corner_t corner;
  logic [NIB_W-1:0] h_off, s_off;
  logic [NIB_W:0] h_cmp, s_cmp;

  assign in_ready      = !s1_valid_r || s1_ready;
  assign in_chan.ready = in_ready;
  assign lookup        = (in_chan.action == ACT_LOOKUP);

  assign h_off = in_chan.hue[NIB_W-1:0];
  assign s_off = in_chan.saturation[NIB_W-1:0];
  assign h_cmp = (NIB_W+1)'(WGT_ONE) - (NIB_W+1)'(h_off);
  assign s_cmp = (NIB_W+1)'(WGT_ONE) - (NIB_W+1)'(s_off);

  always_comb begin
    s1_data_nxt.w[0]   = WGT_W'(h_cmp) * WGT_W'(s_cmp);
    s1_data_nxt.w[1]   = WGT_W'(h_cmp) * WGT_W'(s_off);
    s1_data_nxt.w[2]   = WGT_W'(h_off) * WGT_W'(s_cmp);
    s1_data_nxt.w[3]   = WGT_W'(h_off) * WGT_W'(s_off);
    s1_data_nxt.bright = in_chan.brightness;
    s1_valid_nxt       = in_chan.valid && lookup;
  end

  always_comb begin
    grid_wr.en      = in_chan.valid && in_ready && !lookup &&
                      (in_chan.row_index < IDX_W'(GRID_SIDE)) &&
                      (in_chan.column_index < IDX_W'(GRID_SIDE));
    grid_wr.row     = in_chan.row_index;
    grid_wr.col     = in_chan.column_index;
    grid_wr.data[0] = ENTRY_BITS'(in_chan.red_entry);
    grid_wr.data[1] = ENTRY_BITS'(in_chan.green_entry);
    grid_wr.data[2] = ENTRY_BITS'(in_chan.blue_entry);
    grid_rd.en      = in_ready;
    grid_rd.hrow    = in_chan.hue[PIX_W-1:NIB_W];
    grid_rd.scol    = in_chan.saturation[PIX_W-1:NIB_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s1_valid_nxt) begin
      s1_data_r <= s1_data_nxt;
    end
  end

  hbl_grid u_grid (
    .clk    (clk),
    .wr     (grid_wr),
    .rd     (grid_rd),
    .corner (corner)
  );

  hbl_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (s1_valid_r),
    .s_ready  (s1_ready),
    .s_data   (s1_data_r),
    .s_corner (corner),
    .out_chan (out_chan)
  );

  a_lookup_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && lookup |=> s1_valid_r)
    else $error("accepted lookup item missing from the read stage");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(s1_data_r))
    else $error("read stage item changed while blocked");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid_r)
    else $error("input blocked while the read stage was empty");

endmodule
